### rtl/core/ssm_pkg.sv
package ssm_pkg;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_REMOVE   = 3'd1;
  localparam logic [2:0] OP_GET      = 3'd2;
  localparam logic [2:0] OP_SET      = 3'd3;
  localparam logic [2:0] OP_CONTAINS = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_MISSING = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  key;
    logic [31:0] value_in;
  } req_t;

  typedef struct packed {
    logic        success;
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [8:0]  entry_total;
  } rsp_t;

  typedef struct packed {
    logic latch;
    logic rd_sparse;
    logic rd_dense;
    logic exec;
  } cmd_t;

endpackage

### rtl/core/ssm_ctrl.sv
module ssm_ctrl import ssm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SPARSE = 2'd1;
  localparam logic [1:0] S_DENSE  = 2'd2;
  localparam logic [1:0] S_EXEC   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_SPARSE;
        end
      end
      S_SPARSE: begin
        cmd_o.rd_sparse = 1'b1;
        state_d         = S_DENSE;
      end
      S_DENSE: begin
        cmd_o.rd_dense = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/core/ssm_datapath.sv
module ssm_datapath import ssm_pkg::*; #(
  parameter int KEY_LIMIT   = 255,
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic strobe_o
);

  localparam int SPARSE_DEPTH = (KEY_LIMIT < 255) ? KEY_LIMIT : 255;
  localparam int SADDR_W      = $clog2(SPARSE_DEPTH);
  localparam int SLOT_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  logic [SLOT_W-1:0]      sparse_mem [SPARSE_DEPTH];
  logic [7:0]             key_mem    [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem    [CAPACITY];

  req_t                   req_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [SLOT_W-1:0]      slot_q;
  logic [7:0]             kd_q, lkey_q;
  logic [VALUE_WIDTH-1:0] vd_q, lval_q;
  rsp_t                   rsp_q, rsp_d;
  logic                   strobe_q;

  logic                   key_ok, lkey_ok, present;
  logic [SLOT_W-1:0]      last_idx, dense_raddr;
  logic [SADDR_W-1:0]     sp_raddr;

  logic                   sp_we, k_we, v_we;
  logic [SADDR_W-1:0]     sp_waddr;
  logic [SLOT_W-1:0]      sp_wdata, k_waddr, v_waddr;
  logic [7:0]             k_wdata;
  logic [VALUE_WIDTH-1:0] v_wdata;

  assign key_ok      = (req_q.key != 8'd0) && (32'(req_q.key) <= KEY_LIMIT);
  assign lkey_ok     = (lkey_q != 8'd0) && (32'(lkey_q) <= KEY_LIMIT);
  assign sp_raddr    = SADDR_W'(req_q.key - 8'd1);
  assign last_idx    = SLOT_W'(cnt_q - 1'b1);
  assign dense_raddr = cmd_i.rd_sparse ? last_idx : slot_q;
  assign present     = key_ok && (CNT_W'(slot_q) < cnt_q) && (kd_q == req_q.key);

  always_comb begin
    cnt_d    = cnt_q;
    rsp_d    = '0;
    rsp_d.status = ST_MISSING;
    sp_we    = 1'b0;
    k_we     = 1'b0;
    v_we     = 1'b0;
    sp_waddr = sp_raddr;
    sp_wdata = slot_q;
    k_waddr  = slot_q;
    k_wdata  = lkey_q;
    v_waddr  = slot_q;
    v_wdata  = lval_q;
    if (cmd_i.exec) begin
      if (req_q.key == 8'd0) begin
        rsp_d.status = ST_ZERO;
      end else if (key_ok) begin
        case (req_q.opcode)
          OP_INSERT: begin
            if (present) begin
              rsp_d.status = ST_DUP;
            end else if (cnt_q == CNT_W'(CAPACITY)) begin
              rsp_d.status = ST_FULL;
            end else begin
              sp_we    = 1'b1;
              sp_wdata = SLOT_W'(cnt_q);
              k_we     = 1'b1;
              k_waddr  = SLOT_W'(cnt_q);
              k_wdata  = req_q.key;
              v_we     = 1'b1;
              v_waddr  = SLOT_W'(cnt_q);
              v_wdata  = VALUE_WIDTH'(req_q.value_in);
              cnt_d    = cnt_q + 1'b1;
              rsp_d.success = 1'b1;
              rsp_d.status  = ST_OK;
            end
          end
          OP_REMOVE: begin
            if (present) begin
              sp_we    = lkey_ok;
              sp_waddr = SADDR_W'(lkey_q - 8'd1);
              k_we     = 1'b1;
              v_we     = 1'b1;
              cnt_d    = cnt_q - 1'b1;
              rsp_d.success = 1'b1;
              rsp_d.status  = ST_OK;
            end
          end
          OP_GET: begin
            if (present) begin
              rsp_d.read_value = 32'(vd_q);
              rsp_d.success    = 1'b1;
              rsp_d.status     = ST_OK;
            end
          end
          OP_SET: begin
            if (present) begin
              v_we    = 1'b1;
              v_wdata = VALUE_WIDTH'(req_q.value_in);
              rsp_d.success = 1'b1;
              rsp_d.status  = ST_OK;
            end
          end
          OP_CONTAINS: begin
            if (present) begin
              rsp_d.success = 1'b1;
              rsp_d.status  = ST_OK;
            end
          end
          default: begin
            rsp_d.status = ST_MISSING;
          end
        endcase
      end
    end
    rsp_d.entry_total = 9'(cnt_d);
  end

  // sparse store
  always_ff @(posedge clk_i) begin
    if (sp_we) begin
      sparse_mem[sp_waddr] <= sp_wdata;
    end
    if (cmd_i.rd_sparse && key_ok) begin
      slot_q <= sparse_mem[sp_raddr];
    end
  end

  // dense key store
  always_ff @(posedge clk_i) begin
    if (k_we) begin
      key_mem[k_waddr] <= k_wdata;
    end
    if (cmd_i.rd_sparse || cmd_i.rd_dense) begin
      kd_q <= key_mem[dense_raddr];
    end
  end

  // dense value store
  always_ff @(posedge clk_i) begin
    if (v_we) begin
      val_mem[v_waddr] <= v_wdata;
    end
    if (cmd_i.rd_sparse || cmd_i.rd_dense) begin
      vd_q <= val_mem[dense_raddr];
    end
  end

  // hold last entry, request and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.rd_dense) begin
      lkey_q <= kd_q;
      lval_q <= vd_q;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      strobe_q <= cmd_i.exec;
    end
  end

  assign rsp_o    = rsp_q;
  assign strobe_o = strobe_q;

endmodule

### rtl/core/sparse_set_key_value_map_top.sv
// A taken start is latched, then passes the sparse-slot read, the dense
// key/value read and the execute/write-back states; the execute state registers
// the result and its strobe. Busy covers all three, so a new start is taken only once execute is done.
// Reset (rst_ni low, async) clears the entry count and control; the stores
// are not cleared. The receiver cannot stall a result.
module sparse_set_key_value_map_top import ssm_pkg::*; #(
  parameter int KEY_LIMIT   = 255,
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic strobe_o
);

  cmd_t cmd;

  ssm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  ssm_datapath #(
    .KEY_LIMIT   (KEY_LIMIT),
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .strobe_o (strobe_o)
  );

endmodule

### rtl/core/ssm_checker.sv
module ssm_checker import ssm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input rsp_t rsp_o,
  input logic strobe_o
);

  a_result_after_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 strobe_o)
    else $error("result did not follow transaction after 4 cycles");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("busy during result strobe");

  a_success_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && rsp_o.success) |-> (rsp_o.status == ST_OK))
    else $error("success with non-ok status");

  a_fail_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !rsp_o.success) |-> (rsp_o.read_value == '0))
    else $error("value on failed transaction");

endmodule

bind sparse_set_key_value_map_top ssm_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .req_i    (req_i),
  .rsp_o    (rsp_o),
  .strobe_o (strobe_o)
);
